[src/pcq_pkg.sv]
// Package: shared types and codes of the preemptive command queue.
package pcq_pkg;

    // Input modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_IMM   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Per-cell shift operations
    localparam logic [1:0] CELL_HOLD      = 2'd0;
    localparam logic [1:0] CELL_TAKE_PREV = 2'd1;
    localparam logic [1:0] CELL_TAKE_NEXT = 2'd2;
    localparam logic [1:0] CELL_TAKE_NEW  = 2'd3;

    localparam int ELAPSED_W = 24;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // One stored command
    typedef struct packed {
        logic [3:0]           cmd_type;
        logic signed [7:0]    cmd_priority;
        logic                 cmd_may_interrupt;
        logic [ELAPSED_W-1:0] cmd_lifetime_ms;
        logic signed [31:0]   cmd_argument;
    } cmd_t;

    // Input beat
    typedef struct packed {
        logic [1:0]           mode;
        logic [15:0]          delta_ms;
        logic [3:0]           cmd_type;
        logic signed [7:0]    cmd_priority;
        logic                 cmd_may_interrupt;
        logic [ELAPSED_W-1:0] cmd_lifetime_ms;
        logic signed [31:0]   cmd_argument;
    } req_t;

    // Result beat
    typedef struct packed {
        logic                has_current;
        logic [3:0]          current_type;
        logic signed [31:0]  current_argument;
        logic signed [7:0]   current_priority;
        logic                current_may_interrupt;
        logic [4:0]          pending_count;
        logic                has_previous;
        logic [3:0]          previous_type;
        logic signed [31:0]  previous_argument;
        logic                started;
        logic                expired;
        logic                dropped;
    } rsp_t;

endpackage

[src/pcq_cell.sv]
// One queue cell: holds a command and shifts toward either neighbor.
module pcq_cell
(
    input  logic           clk,
    input  logic [1:0]     op,
    input  pcq_pkg::cmd_t  prev_entry,
    input  pcq_pkg::cmd_t  next_entry,
    input  pcq_pkg::cmd_t  new_entry,
    output pcq_pkg::cmd_t  entry
);

    pcq_pkg::cmd_t entry_reg;
    pcq_pkg::cmd_t entry_next;

    // Select the source of this cell's next entry
    always_comb
    begin
        unique case (op)
            pcq_pkg::CELL_HOLD:      entry_next = entry_reg;
            pcq_pkg::CELL_TAKE_PREV: entry_next = prev_entry;
            pcq_pkg::CELL_TAKE_NEXT: entry_next = next_entry;
            pcq_pkg::CELL_TAKE_NEW:  entry_next = new_entry;
            default:                 entry_next = entry_reg;
        endcase
    end

    // Hold the entry; contents are undefined until written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[src/preemptive_command_queue_with_ttl.sv]
// Top level: active command slot with lifetime timer, fed by a row of queue cells.
// Result: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one item per cycle while results are taken; the queue row shifts
// in that same cycle, and the timer add and lifetime compare set the cycle.
// Reset: clears the fill count, the active and previous commands and the result
// valid flag; queue cells are not reset and read only after being written.
module preemptive_command_queue_with_ttl
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pcq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pcq_pkg::rsp_t  rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [CW-1:0]                  count_reg, count_next;
    pcq_pkg::cmd_t                  active_reg, active_next;
    logic [pcq_pkg::ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                           active_valid_reg, active_valid_next;
    logic [3:0]                     last_type_reg, last_type_next;
    logic signed [31:0]             last_arg_reg, last_arg_next;
    logic                           last_valid_reg, last_valid_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    pcq_pkg::rsp_t                  rsp_reg, rsp_next;

    logic                           req_accept;
    logic                           queue_full;
    logic                           started, expired, dropped;
    logic [pcq_pkg::ELAPSED_W:0]    elapsed_sum;
    logic [pcq_pkg::ELAPSED_W-1:0]  elapsed_sat;
    pcq_pkg::cmd_t                  req_cmd;
    pcq_pkg::cmd_t                  cell_q [QUEUE_DEPTH];
    logic [1:0]                     cell_op [QUEUE_DEPTH];
    logic [1:0]                     shift_op;
    logic                           append;

    assign req_ready  = !rsp_valid_reg || rsp_ready;
    assign req_accept = req_valid && req_ready;
    assign queue_full = (count_reg == DEPTH_C);

    // Pack the incoming command
    always_comb
    begin
        req_cmd.cmd_type          = req.cmd_type;
        req_cmd.cmd_priority      = req.cmd_priority;
        req_cmd.cmd_may_interrupt = req.cmd_may_interrupt;
        req_cmd.cmd_lifetime_ms   = req.cmd_lifetime_ms;
        req_cmd.cmd_argument      = req.cmd_argument;
    end

    // Advance the timer with saturation
    assign elapsed_sum = {1'b0, elapsed_reg}
                       + {{(pcq_pkg::ELAPSED_W - 16 + 1){1'b0}}, req.delta_ms};
    assign elapsed_sat = elapsed_sum[pcq_pkg::ELAPSED_W] ? pcq_pkg::ELAPSED_MAX
                                                         : elapsed_sum[pcq_pkg::ELAPSED_W-1:0];

    // Decide the next slot and queue state for the accepted beat
    always_comb
    begin
        count_next        = count_reg;
        active_next       = active_reg;
        elapsed_next      = elapsed_reg;
        active_valid_next = active_valid_reg;
        last_type_next    = last_type_reg;
        last_arg_next     = last_arg_reg;
        last_valid_next   = last_valid_reg;
        started           = 1'b0;
        expired           = 1'b0;
        dropped           = 1'b0;
        shift_op          = pcq_pkg::CELL_HOLD;
        append            = 1'b0;

        if (req_accept)
        begin
            unique case (req.mode)
                pcq_pkg::MODE_TICK:
                begin
                    if (active_valid_reg)
                    begin
                        elapsed_next = elapsed_sat;
                        if (active_reg.cmd_lifetime_ms != '0 &&
                            elapsed_sat >= active_reg.cmd_lifetime_ms)
                        begin
                            expired           = 1'b1;
                            last_type_next    = active_reg.cmd_type;
                            last_arg_next     = active_reg.cmd_argument;
                            last_valid_next   = 1'b1;
                            active_valid_next = 1'b0;
                        end
                    end
                    // Start the queue front when the slot is or becomes empty
                    if ((!active_valid_reg || expired) && count_reg != '0)
                    begin
                        active_next       = cell_q[0];
                        elapsed_next      = '0;
                        active_valid_next = 1'b1;
                        count_next        = count_reg - CW'(1);
                        shift_op          = pcq_pkg::CELL_TAKE_NEXT;
                        started           = 1'b1;
                    end
                end
                pcq_pkg::MODE_QUEUE:
                begin
                    if (req.cmd_type != '0)
                    begin
                        if (queue_full)
                        begin
                            dropped = 1'b1;
                        end
                        else
                        begin
                            append     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                pcq_pkg::MODE_IMM:
                begin
                    if (req.cmd_type != '0)
                    begin
                        if (active_valid_reg)
                        begin
                            if (queue_full)
                            begin
                                dropped = 1'b1;
                            end
                            else
                            begin
                                shift_op   = pcq_pkg::CELL_TAKE_PREV;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        active_next       = req_cmd;
                        elapsed_next      = '0;
                        active_valid_next = 1'b1;
                    end
                end
                pcq_pkg::MODE_CLEAR:
                begin
                    count_next        = '0;
                    active_valid_next = 1'b0;
                    elapsed_next      = '0;
                    last_valid_next   = 1'b0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Drive each cell: shared shift, or a load at the fill position
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (append && count_reg == CW'(i))
                cell_op[i] = pcq_pkg::CELL_TAKE_NEW;
            else if (append)
                cell_op[i] = pcq_pkg::CELL_HOLD;
            else
                cell_op[i] = shift_op;
        end
    end

    // Row of queue cells, front at cell 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        pcq_pkg::cmd_t prev_in;
        pcq_pkg::cmd_t next_in;

        if (g == 0)
        begin : g_front
            assign prev_in = active_reg;
        end
        else
        begin : g_mid_prev
            assign prev_in = cell_q[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_back
            assign next_in = cell_q[g];
        end
        else
        begin : g_mid_next
            assign next_in = cell_q[g+1];
        end

        pcq_cell u_cell
        (
            .clk        (clk),
            .op         (cell_op[g]),
            .prev_entry (prev_in),
            .next_entry (next_in),
            .new_entry  (req_cmd),
            .entry      (cell_q[g])
        );
    end

    // Build the result beat from the next state
    always_comb
    begin
        rsp_next.has_current           = active_valid_next;
        rsp_next.current_type          = active_valid_next ? active_next.cmd_type : '0;
        rsp_next.current_argument      = active_valid_next ? active_next.cmd_argument : '0;
        rsp_next.current_priority      = active_valid_next ? active_next.cmd_priority : '0;
        rsp_next.current_may_interrupt = active_valid_next && active_next.cmd_may_interrupt;
        rsp_next.pending_count         = 5'(count_next);
        rsp_next.has_previous          = last_valid_next;
        rsp_next.previous_type         = last_valid_next ? last_type_next : '0;
        rsp_next.previous_argument     = last_valid_next ? last_arg_next : '0;
        rsp_next.started               = started;
        rsp_next.expired               = expired;
        rsp_next.dropped               = dropped;
    end

    assign rsp_valid_next = req_accept || (rsp_valid_reg && !rsp_ready);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            active_reg       <= '0;
            elapsed_reg      <= '0;
            active_valid_reg <= 1'b0;
            last_type_reg    <= '0;
            last_arg_reg     <= '0;
            last_valid_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            active_reg       <= active_next;
            elapsed_reg      <= elapsed_next;
            active_valid_reg <= active_valid_next;
            last_type_reg    <= last_type_next;
            last_arg_reg     <= last_arg_next;
            last_valid_reg   <= last_valid_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // Capture the result beat on accept
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Fill count stays within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("queue fill count exceeds depth");

    // An accepted beat yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) req_accept |=> rsp_valid_reg)
        else $error("accepted beat produced no result");

    // An expiry always records a previous command
    assert property (@(posedge clk) disable iff (!rst_n)
                     rsp_valid_reg && rsp_reg.expired |-> rsp_reg.has_previous)
        else $error("expiry without previous command");

    // A start from the queue leaves a current command
    assert property (@(posedge clk) disable iff (!rst_n)
                     rsp_valid_reg && rsp_reg.started |-> rsp_reg.has_current)
        else $error("start without current command");

    // Drops come only from appends and preemptions, never with a start or expiry
    assert property (@(posedge clk) disable iff (!rst_n)
                     rsp_valid_reg && rsp_reg.dropped |-> !rsp_reg.started && !rsp_reg.expired)
        else $error("drop together with start or expiry");

endmodule
